// ----- design/tac_pkg.sv -----
`default_nettype none

package tac_pkg;

	// fixed widths of the datapath
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 17;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = 32;
	localparam int ROOT_W   = 32;
	localparam int REM_W    = 33;
	localparam int R_FRAC   = 16;
	localparam int NORM_W   = 41;
	localparam int XW       = 45;
	localparam int TENTHS_W = 11;
	localparam int PITCH_W  = 10;
	localparam int CFG_W    = 11;
	localparam int SQRT_STEPS = 32;
	localparam int RAD_BITS = 52;

	localparam logic [TENTHS_W-1:0] ROLL_MAX  = 11'd1800;
	localparam logic [PITCH_W-1:0]  PITCH_MAX = 10'd900;
	localparam logic [CFG_W-1:0]    WARN_RST  = 11'd600;
	localparam logic [CFG_W-1:0]    TIP_RST   = 11'd900;

	typedef enum logic [1:0] {
		ST_SAFE,
		ST_WARN,
		ST_OVER
	} tac_status_t;

	typedef enum logic {
		REG_WARN,
		REG_TIP
	} tac_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} tac_sample_t;

	typedef struct packed {
		logic [TENTHS_W-1:0] roll_abs;
		logic [PITCH_W-1:0]  pitch_abs;
		tac_status_t         status;
	} tac_result_t;

	// magnitudes and roll quadrant flag carried beside the square root
	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [MAG_W-1:0] az;
		logic             negz;
	} tac_side_t;

	typedef struct packed {
		logic [63:0] q;
		logic [63:0] r;
	} tac_qr_t;

	// restoring divide, used only when building constants
	function automatic tac_qr_t divmod(input logic [63:0] n, input logic [63:0] d);
		tac_qr_t res;
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		res.q = q;
		res.r = r;
		return res;
	endfunction

	// atan(2^-i) in radians scaled by 2^52, power series
	function automatic logic [63:0] atan_inv_pow2(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int e;
		sum = '0;
		for (int k = 0; k < 32; k++) begin
			e = RAD_BITS - i * (2 * k + 1);
			if (e >= 0) begin
				term = divmod(64'd1 << e, 64'(2 * k + 1)).q;
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		return sum;
	endfunction

	// atan(1/3) scaled by 2^52
	function automatic logic [63:0] atan_third();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		p = divmod(64'd1 << RAD_BITS, 64'd3).q;
		sum = '0;
		for (int k = 0; k < 32; k++) begin
			if (p != '0) begin
				term = divmod(p, 64'(2 * k + 1)).q;
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
				p = divmod(p, 64'd9).q;
			end
		end
		return sum;
	endfunction

	// round(num * 2^fb / den)
	function automatic logic [63:0] div_frac(input logic [63:0] num, input logic [63:0] den,
		input int fb);
		tac_qr_t qr;
		logic [63:0] q;
		logic [63:0] r;
		qr = divmod(num, den);
		q = qr.q;
		r = qr.r;
		for (int b = 0; b < fb + 1; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	// arctangent table entry in tenths of a degree with fb fraction bits
	function automatic logic [63:0] atan_entry(input int i, input int fb);
		logic [63:0] quarter;
		quarter = atan_inv_pow2(1) + atan_third();
		if (i == 0)
			return 64'd450 << fb;
		return div_frac(atan_inv_pow2(i) * 64'd450, quarter, fb);
	endfunction

endpackage

`default_nettype wire

// ----- design/tac_sqrt.sv -----
`default_nettype none

module tac_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_vld,
	input  wire logic [tac_pkg::SUM_W-1:0]     in_sum,
	input  wire tac_pkg::tac_side_t            in_side,
	output logic                               out_vld,
	output logic [tac_pkg::ROOT_W-1:0]         out_root,
	output tac_pkg::tac_side_t                 out_side
);

	localparam int STEPS = tac_pkg::SQRT_STEPS;
	localparam int RW    = tac_pkg::REM_W;
	localparam int OW    = tac_pkg::ROOT_W;
	localparam int SW    = tac_pkg::SUM_W;

	logic                 vld_s  [STEPS];
	logic [RW-1:0]        rem_s  [STEPS];
	logic [OW-1:0]        root_s [STEPS];
	logic [SW-1:0]        sum_s  [STEPS];
	tac_pkg::tac_side_t   side_s [STEPS];

	// one root bit per stage, radicand is sum * 2^32
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic               vld_i;
		logic [RW-1:0]      rem_i;
		logic [OW-1:0]      root_i;
		logic [SW-1:0]      sum_i;
		tac_pkg::tac_side_t side_i;
		logic [RW+1:0]      rem2;
		logic [RW+1:0]      trial;
		logic               ge;

		if (j == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sum_i  = in_sum;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign sum_i  = sum_s[j-1];
			assign side_i = side_s[j-1];
		end

		assign rem2  = {rem_i, sum_i[SW-1 -: 2]};
		assign trial = (RW+2)'({root_i, 2'b01});
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (en)
				vld_s[j] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
				root_s[j] <= {root_i[OW-2:0], ge};
				sum_s[j]  <= sum_i << 2;
				side_s[j] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule

`default_nettype wire

// ----- design/tac_cordic.sv -----
`default_nettype none

module tac_cordic #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_vld,
	input  wire logic [tac_pkg::NORM_W-1:0]      ux,
	input  wire logic [tac_pkg::NORM_W-1:0]      uy,
	input  wire logic                            mirror,
	output logic                                 out_vld,
	output logic [tac_pkg::TENTHS_W-1:0]         tenths
);

	localparam int FB    = ANGLE_FRAC_BITS;
	localparam int ITERS = FB + 10;
	localparam int ANG_W = FB + 12;
	localparam int NW    = tac_pkg::NORM_W;
	localparam int XW    = tac_pkg::XW;
	localparam logic [ANG_W-1:0] FULL = ANG_W'(tac_pkg::ROLL_MAX) << FB;
	localparam logic [ANG_W-1:0] HALF = ANG_W'(1) << (FB - 1);

	logic [NW-1:0] a_c1, b_c1, m_c1, a_c2, b_c2, m_c2;
	logic          vld_s1, mir_s1, vld_s2, mir_s2;
	logic [NW-1:0] a_s1, b_s1, m_s1, a_s2, b_s2;

	// normalize, coarse shifts of 32, 16, 8
	always_comb begin
		a_c1 = ux;
		b_c1 = uy;
		m_c1 = (ux > uy) ? ux : uy;
		for (int k = 0; k < 3; k++) begin
			if ((m_c1 >> (NW - (32 >> k))) == '0) begin
				a_c1 = a_c1 << (32 >> k);
				b_c1 = b_c1 << (32 >> k);
				m_c1 = m_c1 << (32 >> k);
			end
		end
	end

	// normalize, fine shifts of 4, 2, 1
	always_comb begin
		a_c2 = a_s1;
		b_c2 = b_s1;
		m_c2 = m_s1;
		for (int k = 3; k < 6; k++) begin
			if ((m_c2 >> (NW - (32 >> k))) == '0) begin
				a_c2 = a_c2 << (32 >> k);
				b_c2 = b_c2 << (32 >> k);
				m_c2 = m_c2 << (32 >> k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_c1;
			b_s1   <= b_c1;
			m_s1   <= m_c1;
			mir_s1 <= mirror;
			a_s2   <= a_c2;
			b_s2   <= b_c2;
			mir_s2 <= mir_s1;
		end
	end

	logic                    vld_s [ITERS];
	logic                    mir_s [ITERS];
	logic signed [XW-1:0]    x_s   [ITERS];
	logic signed [XW-1:0]    y_s   [ITERS];
	logic signed [ANG_W-1:0] ang_s [ITERS];

	// vectoring iterations, one per stage
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		localparam logic signed [ANG_W-1:0] T_I =
			ANG_W'(tac_pkg::atan_entry(i, ANGLE_FRAC_BITS));
		logic                    vld_i, mir_i;
		logic signed [XW-1:0]    x_i, y_i, dx, dy;
		logic signed [ANG_W-1:0] ang_i;

		if (i == 0) begin : g_first
			assign vld_i = vld_s2;
			assign mir_i = mir_s2;
			assign x_i   = $signed(XW'(a_s2));
			assign y_i   = $signed(XW'(b_s2));
			assign ang_i = '0;
		end else begin : g_next
			assign vld_i = vld_s[i-1];
			assign mir_i = mir_s[i-1];
			assign x_i   = x_s[i-1];
			assign y_i   = y_s[i-1];
			assign ang_i = ang_s[i-1];
		end

		assign dx = y_i >>> i;
		assign dy = x_i >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else if (en)
				vld_s[i] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mir_s[i] <= mir_i;
				if (y_i > 0) begin
					x_s[i]   <= x_i + dx;
					y_s[i]   <= y_i - dy;
					ang_s[i] <= ang_i + T_I;
				end else begin
					x_s[i]   <= x_i - dx;
					y_s[i]   <= y_i + dy;
					ang_s[i] <= ang_i - T_I;
				end
			end
		end
	end

	// clamp at zero, mirror into the second quadrant, round to tenths
	logic [ANG_W-1:0] ang_pos, ang_mir, ang_rnd;
	logic             vld_sf;
	logic [tac_pkg::TENTHS_W-1:0] tenths_sf;

	assign ang_pos = ang_s[ITERS-1][ANG_W-1] ? '0 : ang_s[ITERS-1];
	assign ang_mir = mir_s[ITERS-1] ? (FULL - ang_pos) : ang_pos;
	assign ang_rnd = (ang_mir + HALF) >> FB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sf <= 1'b0;
		else if (en)
			vld_sf <= vld_s[ITERS-1];
	end

	always_ff @(posedge clk) begin
		if (en)
			tenths_sf <= ang_rnd[tac_pkg::TENTHS_W-1:0];
	end

	assign out_vld = vld_sf;
	assign tenths  = tenths_sf;

endmodule

`default_nettype wire

// ----- design/tilt_angle_classifier_core.sv -----
// Tilt classifier for one three-axis accelerometer sample per transfer.
// Input channel: sample_valid / sample_ready with the signed x, y, z counts.
// Output channel: result_valid / result_ready with |roll| and |pitch| in
// tenths of a degree and a status of safe, warning or overturned.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (warning threshold, overturned threshold) in the same cycle.
// Path from input transfer to result_valid: three front stages, the 32-stage
// square root, six normalizing shifts over two stages, the unrolled CORDIC of
// ANGLE_FRAC_BITS + 10 iterations, its rounding stage and the output register.
// Throughput: one sample per cycle while the skid entry is free, every stage is a plain register stage.
// Stall: the output has a register plus one skid entry; while the skid entry
// is occupied the whole pipeline holds and sample_ready is low, so nothing is
// dropped or repeated.
// Reset: clears all valid bits and the skid, and loads the thresholds with
// 600 and 900 tenths of a degree.
`default_nettype none

module tilt_angle_classifier_core #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire tac_pkg::tac_sample_t          sample,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output tac_pkg::tac_result_t               result,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [tac_pkg::CFG_W-1:0]     cfg_data
);

	localparam int MW = tac_pkg::MAG_W;

	function automatic logic [MW-1:0] mag(input logic signed [tac_pkg::SAMPLE_W-1:0] v);
		logic signed [MW-1:0] e;
		e = MW'(v);
		return v[tac_pkg::SAMPLE_W-1] ? MW'(-e) : MW'(e);
	endfunction

	// threshold registers
	logic [tac_pkg::CFG_W-1:0] warn_q, tip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q <= tac_pkg::WARN_RST;
			tip_q  <= tac_pkg::TIP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tac_pkg::REG_WARN: warn_q <= cfg_data;
				tac_pkg::REG_TIP:  tip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic spare_vld_q;

	assign en           = !spare_vld_q;
	assign sample_ready = en;

	// front stages: magnitudes, squares, sum of squares
	logic                       vld_s1, vld_s2, vld_s3;
	tac_pkg::tac_side_t         side_s1, side_s2, side_s3;
	logic [2*MW-1:0]            py, pz;
	logic [tac_pkg::SQ_W-1:0]   sqy_s2, sqz_s2;
	logic [tac_pkg::SUM_W-1:0]  sum_s3;

	assign py = side_s1.ay * side_s1.ay;
	assign pz = side_s1.az * side_s1.az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ax   <= mag(sample.accel_x);
			side_s1.ay   <= mag(sample.accel_y);
			side_s1.az   <= mag(sample.accel_z);
			side_s1.negz <= sample.accel_z[tac_pkg::SAMPLE_W-1];
			sqy_s2       <= py[tac_pkg::SQ_W-1:0];
			sqz_s2       <= pz[tac_pkg::SQ_W-1:0];
			side_s2      <= side_s1;
			sum_s3       <= tac_pkg::SUM_W'(sqy_s2) + tac_pkg::SUM_W'(sqz_s2);
			side_s3      <= side_s2;
		end
	end

	// radius with 16 fraction bits
	logic                        sq_vld;
	logic [tac_pkg::ROOT_W-1:0]  sq_root;
	tac_pkg::tac_side_t          sq_side;

	tac_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_sum   (sum_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// roll and pitch angle units side by side
	logic                           roll_vld, pitch_vld;
	logic [tac_pkg::TENTHS_W-1:0]   roll_t, pitch_t;
	logic [tac_pkg::NORM_W-1:0]     pitch_uy;

	assign pitch_uy = tac_pkg::NORM_W'({sq_side.ax, {tac_pkg::R_FRAC{1'b0}}});

	tac_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.ux      (tac_pkg::NORM_W'(sq_side.az)),
		.uy      (tac_pkg::NORM_W'(sq_side.ay)),
		.mirror  (sq_side.negz),
		.out_vld (roll_vld),
		.tenths  (roll_t)
	);

	tac_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.ux      (tac_pkg::NORM_W'(sq_root)),
		.uy      (pitch_uy),
		.mirror  (1'b0),
		.out_vld (pitch_vld),
		.tenths  (pitch_t)
	);

	// clamp, take the larger angle, classify
	logic [tac_pkg::TENTHS_W-1:0] roll_c, mx;
	logic [tac_pkg::PITCH_W-1:0]  pitch_c;
	tac_pkg::tac_result_t         res_new;

	always_comb begin
		roll_c  = (roll_t > tac_pkg::ROLL_MAX) ? tac_pkg::ROLL_MAX : roll_t;
		pitch_c = (pitch_t > tac_pkg::TENTHS_W'(tac_pkg::PITCH_MAX)) ?
			tac_pkg::PITCH_MAX : pitch_t[tac_pkg::PITCH_W-1:0];
		mx = (roll_c > tac_pkg::TENTHS_W'(pitch_c)) ? roll_c : tac_pkg::TENTHS_W'(pitch_c);
		res_new.roll_abs  = roll_c;
		res_new.pitch_abs = pitch_c;
		if (mx >= tip_q)
			res_new.status = tac_pkg::ST_OVER;
		else if (mx >= warn_q)
			res_new.status = tac_pkg::ST_WARN;
		else
			res_new.status = tac_pkg::ST_SAFE;
	end

	// output register with one skid entry
	logic                 out_vld_q;
	tac_pkg::tac_result_t out_q, spare_q;
	logic                 push, pop;

	assign push = en && roll_vld;
	assign pop  = out_vld_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (pop) begin
			if (spare_vld_q) begin
				spare_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (out_vld_q)
				spare_vld_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (spare_vld_q)
				out_q <= spare_q;
			else if (push)
				out_q <= res_new;
		end else if (push) begin
			if (out_vld_q)
				spare_q <= res_new;
			else
				out_q <= res_new;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		roll_vld == pitch_vld)
		else $error("roll and pitch units out of step");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		spare_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");

	a_over_reached: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == tac_pkg::ST_OVER |->
		(result.roll_abs >= tip_q || tac_pkg::TENTHS_W'(result.pitch_abs) >= tip_q))
		else $error("overturned status below threshold");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.pitch_abs <= tac_pkg::PITCH_MAX)
		else $error("pitch beyond quarter turn");
`endif

endmodule

`default_nettype wire

// ----- verif/tilt_angle_classifier_core_test.sv -----
`timescale 1ns / 1ps

module tilt_angle_classifier_core_test;

	localparam int FB       = 16;
	localparam int ITERS    = FB + 10;
	localparam int SETTLE   = 90;

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_ready;
	tac_pkg::tac_sample_t       sample;
	logic                       result_valid;
	logic                       result_ready;
	tac_pkg::tac_result_t       result;
	logic                       cfg_we;
	logic [0:0]                 cfg_index;
	logic [tac_pkg::CFG_W-1:0]  cfg_data;

	tilt_angle_classifier_core #(.ANGLE_FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the thresholds and the arctangent table
	logic [tac_pkg::CFG_W-1:0]  warn_thr;
	logic [tac_pkg::CFG_W-1:0]  tip_thr;
	longint unsigned            atan_lut [ITERS];
	tac_pkg::tac_result_t       pending_results [$];
	int                         fails;
	bit                         calm;

	typedef struct {
		logic signed [15:0]   x;
		logic signed [15:0]   y;
		logic signed [15:0]   z;
		bit                   typed;
		tac_pkg::tac_result_t want;
	} stim_row_t;

	always #5 clk = ~clk;

	// arctangent of 2^-i in radians at 2^-52 resolution
	function automatic longint unsigned series_atan(int i);
		longint unsigned acc;
		int e;
		acc = 0;
		for (int k = 0; k < 64; k++) begin
			e = tac_pkg::RAD_BITS - i * (2 * k + 1);
			if (e < 0)
				break;
			if (k % 2)
				acc -= (64'd1 << e) / longint'(2 * k + 1);
			else
				acc += (64'd1 << e) / longint'(2 * k + 1);
		end
		return acc;
	endfunction

	function automatic longint unsigned series_atan_third();
		longint unsigned p;
		longint unsigned acc;
		longint unsigned k;
		p = (64'd1 << tac_pkg::RAD_BITS) / 3;
		acc = 0;
		k = 0;
		while (p != 0) begin
			if (k % 2)
				acc -= p / (2 * k + 1);
			else
				acc += p / (2 * k + 1);
			p /= 9;
			k++;
		end
		return acc;
	endfunction

	// round(num * 2^fb / den) by long division
	function automatic longint unsigned scaled_ratio(longint unsigned num,
		longint unsigned den, int fb);
		longint unsigned q;
		longint unsigned r;
		q = num / den;
		r = num % den;
		for (int b = 0; b < fb + 1; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned one;
		res = 0;
		one = 64'd1 << 62;
		while (one > n)
			one >>= 2;
		while (one != 0) begin
			if (n >= res + one) begin
				n -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	// first-quadrant vectoring angle, zero for the zero vector
	function automatic longint vector_angle(longint unsigned ux, longint unsigned uy);
		longint unsigned m;
		longint vx;
		longint vy;
		longint ang;
		longint dx;
		longint dy;
		m = ux > uy ? ux : uy;
		ang = 0;
		if (m == 0)
			return 0;
		while (m < (64'd1 << 40)) begin
			ux <<= 1;
			uy <<= 1;
			m <<= 1;
		end
		vx = longint'(ux);
		vy = longint'(uy);
		for (int i = 0; i < ITERS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy > 0) begin
				vx += dx;
				vy -= dy;
				ang += longint'(atan_lut[i]);
			end else begin
				vx -= dx;
				vy += dy;
				ang -= longint'(atan_lut[i]);
			end
		end
		return ang < 0 ? 0 : ang;
	endfunction

	function automatic longint unsigned round_tenths(longint ang, longint unsigned lim);
		longint unsigned t;
		if (ang < 0)
			ang = 0;
		t = (longint'(ang) + (64'd1 << (FB - 1))) >> FB;
		return t > lim ? lim : t;
	endfunction

	function automatic tac_pkg::tac_result_t predict_tilt(tac_pkg::tac_sample_t s);
		tac_pkg::tac_result_t r;
		longint sx;
		longint sy;
		longint sz;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned az;
		longint unsigned rad;
		longint unsigned roll;
		longint unsigned pitch;
		longint unsigned peak;
		longint roll_ang;
		sx = s.accel_x;
		sy = s.accel_y;
		sz = s.accel_z;
		ax = sx < 0 ? -sx : sx;
		ay = sy < 0 ? -sy : sy;
		az = sz < 0 ? -sz : sz;
		// roll with negative z mirrors about 90 degrees
		if (ay == 0 && az == 0)
			roll_ang = 0;
		else if (sz >= 0)
			roll_ang = vector_angle(az, ay);
		else
			roll_ang = (longint'(1800) << FB) - vector_angle(az, ay);
		rad = int_sqrt((ay * ay + az * az) << 32);
		roll = round_tenths(roll_ang, 1800);
		pitch = round_tenths(vector_angle(rad, ax << 16), 900);
		peak = roll > pitch ? roll : pitch;
		r.roll_abs = roll[tac_pkg::TENTHS_W-1:0];
		r.pitch_abs = pitch[tac_pkg::PITCH_W-1:0];
		if (peak >= tip_thr)
			r.status = tac_pkg::ST_OVER;
		else if (peak >= warn_thr)
			r.status = tac_pkg::ST_WARN;
		else
			r.status = tac_pkg::ST_SAFE;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// output side: draw a stall per transfer
	int stall_left;
	always @(posedge clk) begin
		int w;
		if (result_valid && result_ready) begin
			w = calm ? 0 : $urandom_range(0, 11);
			result_ready <= (w == 0);
			stall_left <= w;
		end else if (!result_ready) begin
			if (stall_left <= 1)
				result_ready <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		tac_pkg::tac_result_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result roll", result.roll_abs, -1);
			end else begin
				e = pending_results.pop_front();
				if (result.roll_abs !== e.roll_abs)
					report_mismatch("roll_abs", result.roll_abs, e.roll_abs);
				if (result.pitch_abs !== e.pitch_abs)
					report_mismatch("pitch_abs", result.pitch_abs, e.pitch_abs);
				if (result.status !== e.status)
					report_mismatch("status", result.status, e.status);
			end
		end
	end

	// one input transfer, returns at the accepting edge
	task automatic send_sample(tac_pkg::tac_sample_t s, bit typed,
		tac_pkg::tac_result_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		pending_results.push_back(typed ? want : predict_tilt(s));
	endtask

	task automatic drain_all();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_thresholds(logic [tac_pkg::CFG_W-1:0] warn,
		logic [tac_pkg::CFG_W-1:0] tip);
		cfg_we <= 1'b1;
		cfg_index <= tac_pkg::REG_WARN;
		cfg_data <= warn;
		@(posedge clk);
		cfg_index <= tac_pkg::REG_TIP;
		cfg_data <= tip;
		@(posedge clk);
		cfg_we <= 1'b0;
		warn_thr = warn;
		tip_thr = tip;
	endtask

	function automatic logic signed [15:0] draw_axis(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $urandom_range(0, 3) == 0 ? 16'sd0 : 16'($urandom);
		endcase
	endfunction

	task automatic random_burst(int count);
		tac_pkg::tac_sample_t s;
		int mode;
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 5);
			s.accel_x = draw_axis(mode % 4);
			s.accel_y = draw_axis(mode % 4);
			s.accel_z = draw_axis(mode % 4);
			send_sample(s, 1'b0, '0);
			// let the pipeline run dry once mid-stream
			if (n == count / 2 && count > 100)
				drain_all();
		end
		calm = 0;
	endtask

	stim_row_t directed [$];

	initial begin
		stim_row_t row;
		tac_pkg::tac_sample_t s;
		longint unsigned quarter;
		logic [tac_pkg::CFG_W-1:0] settings [6][2];

		clk = 0;
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		result_ready = 1;
		cfg_we = 0;
		cfg_index = tac_pkg::REG_WARN;
		cfg_data = '0;
		fails = 0;
		calm = 0;
		stall_left = 0;
		warn_thr = tac_pkg::WARN_RST;
		tip_thr = tac_pkg::TIP_RST;

		quarter = series_atan(1) + series_atan_third();
		atan_lut[0] = 64'd450 << FB;
		for (int i = 1; i < ITERS; i++)
			atan_lut[i] = scaled_ratio(series_atan(i) * 450, quarter, FB);

		// directed rows, typed results only where obvious
		row = '{0, 0, 0, 1, '{11'd0, 10'd0, tac_pkg::ST_SAFE}};
		directed.push_back(row);
		row = '{0, 0, 100, 1, '{11'd0, 10'd0, tac_pkg::ST_SAFE}};
		directed.push_back(row);
		row = '{0, 0, -100, 1, '{11'd1800, 10'd0, tac_pkg::ST_OVER}};
		directed.push_back(row);
		row = '{0, 0, 32767, 1, '{11'd0, 10'd0, tac_pkg::ST_SAFE}};
		directed.push_back(row);
		row = '{0, 0, -32768, 1, '{11'd1800, 10'd0, tac_pkg::ST_OVER}};
		directed.push_back(row);
		row = '{0, 0, 1, 1, '{11'd0, 10'd0, tac_pkg::ST_SAFE}};
		directed.push_back(row);
		row = '{0, 0, -1, 1, '{11'd1800, 10'd0, tac_pkg::ST_OVER}};
		directed.push_back(row);
		row = '{100, 0, 0, 0, '0};          directed.push_back(row);
		row = '{-32768, 0, 0, 0, '0};       directed.push_back(row);
		row = '{32767, 0, 0, 0, '0};        directed.push_back(row);
		row = '{0, 100, 0, 0, '0};          directed.push_back(row);
		row = '{0, -32768, 0, 0, '0};       directed.push_back(row);
		row = '{0, 32767, 32767, 0, '0};    directed.push_back(row);
		row = '{0, 100, -100, 0, '0};       directed.push_back(row);
		row = '{-32768, -32768, -32768, 0, '0}; directed.push_back(row);
		row = '{32767, 32767, 32767, 0, '0};    directed.push_back(row);
		row = '{1, 1, 1, 0, '0};            directed.push_back(row);
		row = '{-1, -1, -1, 0, '0};         directed.push_back(row);
		row = '{0, 1000, 1732, 0, '0};      directed.push_back(row);
		row = '{0, 1732, 1000, 0, '0};      directed.push_back(row);
		row = '{5000, 0, 8660, 0, '0};      directed.push_back(row);
		row = '{0, 1, -32768, 0, '0};       directed.push_back(row);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			s.accel_x = directed[i].x;
			s.accel_y = directed[i].y;
			s.accel_z = directed[i].z;
			send_sample(s, directed[i].typed, directed[i].want);
		end
		random_burst(250);
		drain_all();

		settings = '{'{11'd0, 11'd0}, '{11'd1800, 11'd1800}, '{11'd2047, 11'd2047},
			'{11'd1000, 11'd500}, '{11'd300, 11'd450}, '{11'd0, 11'd0}};
		settings[5][0] = 11'($urandom_range(0, 1800));
		settings[5][1] = 11'($urandom_range(0, 1800));
		for (int p = 0; p < 6; p++) begin
			write_thresholds(settings[p][0], settings[p][1]);
			random_burst(215);
			drain_all();
		end

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
